FILE: rtl/rmsd_pkg.sv
package rmsd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int COUNT_BITS_DEF = 16;

    // divider shift register and quotient lengths
    localparam int DIV_SR_W = 31;
    localparam int MEAN_Q_W = 16;
    localparam int SQ_Q_W = 31;

    // square root operand, root accumulator and step count
    localparam int ROOT_IN_W = 31;
    localparam int ROOT_W = 32;
    localparam int ROOT_STEPS = 16;

    localparam int ITER_W = 5;
    localparam int PROD_W = 2 * SAMPLE_W;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_PREEMPT = 2'd2;

    localparam logic [1:0] OUTC_RUNNING = 2'd0;
    localparam logic [1:0] OUTC_SUCCESS = 2'd1;
    localparam logic [1:0] OUTC_ABORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GOAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

    localparam logic [CFG_DATA_W-1:0] GOAL_RESET = 16'd10;
    localparam logic signed [CFG_DATA_W-1:0] THRESH_RESET = 16'sd1280;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [15:0]                sample_index;
        logic signed [SAMPLE_W-1:0] sample_echo;
        logic signed [SAMPLE_W-1:0] mean;
        logic [15:0]                std_dev;
        logic                       done_res;
        logic [1:0]                 outcome;
    } out_beat_t;

endpackage

FILE: rtl/rmsd_stream_if.sv
interface rmsd_stream_if #(
    parameter type beat_t = logic
) ();

    logic  valid;
    logic  ready;
    beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

FILE: rtl/running_mean_stddev_unit.sv
// Running mean and standard deviation of signed Q8.8 samples. A start command clears the
// count and both sums and arms the unit; a preempt command disarms it. Each sample taken while
// armed yields one result beat with the count, the sample, the truncated mean and the truncated
// standard deviation sqrt(|sumsq/count - mean^2|); the beat that pushes the count past
// goal_samples (or to the counter ceiling) is flagged done, with success when the mean is at
// least mean_threshold, and disarms the unit. Commands and ignored samples keep the unit idle. A
// sample runs to completion before the next accept: one shared 16x16 multiplier is used
// twice, a one-bit-per-cycle restoring divider runs 16 steps for the mean and 31 steps for the
// mean square, and a one-digit-per-cycle square root runs 16 steps. The sample input is not
// ready while it runs. A finished beat waits in the output register without holding off
// further commands; the next sample holds in its last step until that register is free.
module running_mean_stddev_unit #(
    parameter int COUNT_BITS = rmsd_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rmsd_stream_if.sink                         samples,
    rmsd_stream_if.source                       results,
    input  logic                                cfg_we,
    input  logic [rmsd_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [rmsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = rmsd_pkg::SAMPLE_W;
    localparam int SUM_W = SW + COUNT_BITS;
    localparam int SQ_W = 2 * SW - 2 + COUNT_BITS;
    localparam int CMP_W = (COUNT_BITS > SW) ? COUNT_BITS : SW;
    localparam int PW = rmsd_pkg::PROD_W;
    localparam int DW = rmsd_pkg::DIV_SR_W;
    localparam int IW = rmsd_pkg::ITER_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_DIVM = 4'd3;
    localparam logic [3:0] ST_MULM = 4'd4;
    localparam logic [3:0] ST_DIVQ = 4'd5;
    localparam logic [3:0] ST_DIFF = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    logic [3:0]                         state_reg;
    logic [3:0]                         state_next;
    logic                               active_reg;
    logic [rmsd_pkg::CFG_DATA_W-1:0]    goal_reg;
    logic signed [SW-1:0]               thresh_reg;
    logic [COUNT_BITS-1:0]              count_reg;
    logic signed [SUM_W-1:0]            sum_reg;
    logic [SQ_W-1:0]                    sq_reg;
    logic                               out_valid_reg;
    rmsd_pkg::out_beat_t                out_data_reg;

    logic signed [SW-1:0]               x_reg;
    logic [PW-1:0]                      prod_reg;
    logic [COUNT_BITS-1:0]              rem_reg;
    logic [DW-1:0]                      qr_reg;
    logic [IW-1:0]                      iter_reg;
    logic signed [SW-1:0]               mean_reg;
    logic [rmsd_pkg::ROOT_IN_W-1:0]     v_reg;
    logic [rmsd_pkg::ROOT_W-1:0]        root_reg;
    logic [rmsd_pkg::ROOT_IN_W-1:0]     bit_reg;

    logic                               accept;
    logic                               take_sample;
    logic                               out_free;
    logic [SW-1:0]                      x_mag;
    logic [SUM_W-1:0]                   sum_mag;
    logic [SW-1:0]                      mul_op;
    logic [PW-1:0]                      mul_a;
    logic [PW-1:0]                      mul_res;
    logic [COUNT_BITS:0]                div_trial;
    logic [COUNT_BITS:0]                div_sub;
    logic                               div_ge;
    logic [COUNT_BITS-1:0]              rem_step;
    logic [DW-1:0]                      qr_step;
    logic [rmsd_pkg::ROOT_W-1:0]        sq_trial;
    logic                               sq_ge;
    logic [rmsd_pkg::ROOT_IN_W-1:0]     v_step;
    logic [rmsd_pkg::ROOT_W-1:0]        root_step;
    logic [PW:0]                        q_ext;
    logic [PW:0]                        p_ext;
    logic [PW:0]                        dq;
    logic [CMP_W-1:0]                   count_ext;
    logic                               done;
    logic                               mean_ge;
    rmsd_pkg::out_beat_t                out_next;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept = samples.valid && samples.ready;
    assign take_sample = accept && (samples.data.cmd == rmsd_pkg::CMD_SAMPLE) && active_reg;
    assign out_free = !out_valid_reg || results.ready;
    assign results.valid = out_valid_reg;
    assign results.data = out_data_reg;

    // shared multiplier
    assign x_mag = x_reg[SW-1] ? SW'(-x_reg) : x_reg;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mul_op = (state_reg == ST_SQX) ? x_mag : qr_reg[rmsd_pkg::MEAN_Q_W-1:0];
    assign mul_a = {{(PW-SW){1'b0}}, mul_op};
    assign mul_res = mul_a * mul_a;

    // restoring divider step, divisor is the count
    assign div_trial = {rem_reg, qr_reg[DW-1]};
    assign div_sub = div_trial - {1'b0, count_reg};
    assign div_ge = div_trial >= {1'b0, count_reg};
    assign rem_step = div_ge ? div_sub[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
    assign qr_step = {qr_reg[DW-2:0], div_ge};

    // square root digit step
    assign sq_trial = root_reg + {1'b0, bit_reg};
    assign sq_ge = {1'b0, v_reg} >= sq_trial;
    assign v_step = sq_ge ? (v_reg - sq_trial[rmsd_pkg::ROOT_IN_W-1:0]) : v_reg;
    assign root_step = sq_ge ? ((root_reg >> 1) + {1'b0, bit_reg}) : (root_reg >> 1);

    assign q_ext = {{(PW+1-DW){1'b0}}, qr_reg};
    assign p_ext = {1'b0, prod_reg};
    assign dq = (q_ext >= p_ext) ? (q_ext - p_ext) : (p_ext - q_ext);

    assign count_ext = CMP_W'(count_reg);
    assign done = (count_ext > CMP_W'(goal_reg)) || (count_reg == COUNT_MAX);
    assign mean_ge = mean_reg >= thresh_reg;

    always_comb
    begin
        out_next.sample_index = count_ext[15:0];
        out_next.sample_echo = x_reg;
        out_next.mean = mean_reg;
        out_next.std_dev = root_reg[15:0];
        out_next.done_res = done;
        if (!done)
        begin
            out_next.outcome = rmsd_pkg::OUTC_RUNNING;
        end
        else if (mean_ge)
        begin
            out_next.outcome = rmsd_pkg::OUTC_SUCCESS;
        end
        else
        begin
            out_next.outcome = rmsd_pkg::OUTC_ABORT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIVM;
            ST_DIVM:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_MULM;
                end
            end
            ST_MULM: state_next = ST_DIVQ;
            ST_DIVQ:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            active_reg <= 1'b0;
            goal_reg <= rmsd_pkg::GOAL_RESET;
            thresh_reg <= rmsd_pkg::THRESH_RESET;
            count_reg <= '0;
            sum_reg <= '0;
            sq_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_idx)
                    rmsd_pkg::REG_GOAL:   goal_reg <= cfg_data;
                    rmsd_pkg::REG_THRESH: thresh_reg <= cfg_data;
                    default:              goal_reg <= goal_reg;
                endcase
            end
            if (accept)
            begin
                case (samples.data.cmd)
                    rmsd_pkg::CMD_START:
                    begin
                        count_reg <= '0;
                        sum_reg <= '0;
                        sq_reg <= '0;
                        active_reg <= 1'b1;
                    end
                    rmsd_pkg::CMD_PREEMPT:
                    begin
                        active_reg <= 1'b0;
                    end
                    rmsd_pkg::CMD_SAMPLE:
                    begin
                        if (active_reg)
                        begin
                            count_reg <= count_reg + COUNT_BITS'(1);
                            sum_reg <= sum_reg + SUM_W'(samples.data.sample);
                        end
                    end
                    default:
                    begin
                        active_reg <= active_reg;
                    end
                endcase
            end
            if (state_reg == ST_ACC)
            begin
                sq_reg <= sq_reg + SQ_W'(prod_reg);
            end
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (done)
                begin
                    active_reg <= 1'b0;
                end
            end
            else if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            x_reg <= samples.data.sample;
        end
        case (state_reg)
            ST_SQX:
            begin
                prod_reg <= mul_res;
            end
            ST_ACC:
            begin
                rem_reg <= sum_mag[SUM_W-1:rmsd_pkg::MEAN_Q_W];
                qr_reg <= {sum_mag[rmsd_pkg::MEAN_Q_W-1:0], {(DW-rmsd_pkg::MEAN_Q_W){1'b0}}};
                iter_reg <= IW'(rmsd_pkg::MEAN_Q_W - 1);
            end
            ST_DIVM, ST_DIVQ:
            begin
                rem_reg <= rem_step;
                qr_reg <= qr_step;
                iter_reg <= iter_reg - IW'(1);
            end
            ST_MULM:
            begin
                prod_reg <= mul_res;
                mean_reg <= sum_reg[SUM_W-1] ? (SW'(0) - qr_reg[rmsd_pkg::MEAN_Q_W-1:0])
                                             : qr_reg[rmsd_pkg::MEAN_Q_W-1:0];
                rem_reg <= {1'b0, sq_reg[SQ_W-1:rmsd_pkg::SQ_Q_W]};
                qr_reg <= sq_reg[rmsd_pkg::SQ_Q_W-1:0];
                iter_reg <= IW'(rmsd_pkg::SQ_Q_W - 1);
            end
            ST_DIFF:
            begin
                v_reg <= dq[rmsd_pkg::ROOT_IN_W-1:0];
                root_reg <= '0;
                bit_reg <= {1'b1, {(rmsd_pkg::ROOT_IN_W-1){1'b0}}};
                iter_reg <= IW'(rmsd_pkg::ROOT_STEPS - 1);
            end
            ST_SQRT:
            begin
                v_reg <= v_step;
                root_reg <= root_step;
                bit_reg <= bit_reg >> 2;
                iter_reg <= iter_reg - IW'(1);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg <= out_next;
                end
            end
            default:
            begin
                iter_reg <= iter_reg;
            end
        endcase
    end

    // divider remainder must stay below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVM || state_reg == ST_DIVQ) |-> (rem_reg < count_reg))
        else $error("divider remainder not below count");

    // a finished beat always carries a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.done_res) |->
            (results.data.outcome == rmsd_pkg::OUTC_SUCCESS ||
             results.data.outcome == rmsd_pkg::OUTC_ABORT))
        else $error("done beat without outcome");

    // an armed sample starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        take_sample |=> (state_reg == ST_SQX && !samples.ready))
        else $error("armed sample did not start a run");

    // inactive or command beats never start the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !take_sample) |=> (state_reg == ST_IDLE))
        else $error("command beat left idle");

endmodule
